// ===== design/kag_pkg.sv =====
// Shared types, constants and helpers for the Kepler anomaly gradient block.
package kag_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int ANG_W = 32;
	localparam int CV_W = 34;
	localparam int DIV_W = 48;
	localparam int OUT_W = 48;
	localparam int MAG_W = 60;

	localparam logic signed [32:0] ANG_TWO_PI = 33'sd1686629713;
	localparam logic signed [32:0] ANG_PI = 33'sd843314857;
	localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
	localparam logic signed [CV_W-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [51:0] ONE_Q46 = 52'sd70368744177664;
	localparam logic signed [51:0] DEN_MIN = 52'sd1073741824;
	localparam logic [MAG_W-1:0] OUT_MAX = 60'd140737488355327;

	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [CV_W-1:0] cval_t;
	typedef logic signed [OUT_W-1:0] res_t;

	// sideband riding along the rotation pipeline
	typedef struct packed {
		logic [15:0] ecc;
		logic        gneg;
		logic [31:0] num;
	} csd_t;

	// sideband riding along the divider pipeline
	typedef struct packed {
		logic  gneg;
		cval_t sn;
	} dsd_t;

	function automatic ang_t atan_step(input int i);
		ang_t r;
		case (i)
			0: r = 32'sd210828714;
			1: r = 32'sd124459457;
			2: r = 32'sd65760959;
			3: r = 32'sd33381290;
			4: r = 32'sd16755422;
			5: r = 32'sd8385879;
			6: r = 32'sd4193963;
			7: r = 32'sd2097109;
			8: r = 32'sd1048571;
			9: r = 32'sd524287;
			default: r = (i <= 28) ? ang_t'(32'sd1 <<< (28 - i)) : '0;
		endcase
		return r;
	endfunction

	function automatic res_t sat48(input logic neg, input logic [MAG_W-1:0] mag);
		res_t r;
		if (neg) begin
			if (mag > OUT_MAX) r = {1'b1, {(OUT_W-1){1'b0}}};
			else r = res_t'(-mag);
		end else begin
			if (mag > OUT_MAX) r = {1'b0, {(OUT_W-1){1'b1}}};
			else r = res_t'(mag);
		end
		return r;
	endfunction

endpackage

// ===== design/kag_if.sv =====
// Stream interfaces for input words and result words.
interface kag_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] ecc_anomaly;
	logic        [15:0] eccentricity;
	logic signed [31:0] upstream_grad;
	modport source (output valid, ecc_anomaly, eccentricity, upstream_grad, input ready);
	modport sink (input valid, ecc_anomaly, eccentricity, upstream_grad, output ready);
endinterface

interface kag_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] grad_mean_anomaly;
	logic signed [47:0] grad_eccentricity;
	modport source (output valid, grad_mean_anomaly, grad_eccentricity, input ready);
	modport sink (input valid, grad_mean_anomaly, grad_eccentricity, output ready);
endinterface

// ===== design/kag_cordic.sv =====
// Pipelined rotation CORDIC, one iteration per stage.
module kag_cordic #(
	parameter int STAGES = kag_pkg::CORDIC_STAGES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_in,
	input  kag_pkg::ang_t  z_in,
	input  logic           flip_in,
	input  kag_pkg::csd_t  side_in,
	output logic           v_out,
	output kag_pkg::cval_t sn,
	output kag_pkg::cval_t cs,
	output kag_pkg::csd_t  side_out
);
	import kag_pkg::*;

	logic  v_s    [STAGES];
	cval_t x_s    [STAGES];
	cval_t y_s    [STAGES];
	ang_t  z_s    [STAGES];
	logic  flip_s [STAGES];
	csd_t  side_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_st
		logic  vp, fp;
		cval_t xp, yp;
		ang_t  zp;
		csd_t  sp;
		if (i == 0) begin : g_first
			assign vp = v_in;
			assign xp = CORDIC_K;
			assign yp = '0;
			assign zp = z_in;
			assign fp = flip_in;
			assign sp = side_in;
		end else begin : g_next
			assign vp = v_s[i-1];
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign fp = flip_s[i-1];
			assign sp = side_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[ANG_W-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - atan_step(i);
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + atan_step(i);
				end
				flip_s[i] <= fp;
				side_s[i] <= sp;
			end
		end
	end

	assign v_out    = v_s[STAGES-1];
	assign sn       = flip_s[STAGES-1] ? -y_s[STAGES-1] : y_s[STAGES-1];
	assign cs       = flip_s[STAGES-1] ? -x_s[STAGES-1] : x_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule

// ===== design/kag_div.sv =====
// Pipelined restoring divider: q = num * 2^46 / den, one quotient bit per stage.
module kag_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      v_in,
	input  logic [31:0]               num,
	input  logic [kag_pkg::DIV_W-1:0] den,
	input  kag_pkg::dsd_t             side_in,
	output logic                      v_out,
	output logic [kag_pkg::DIV_W-1:0] q,
	output kag_pkg::dsd_t             side_out
);
	import kag_pkg::*;

	logic             v_s    [DIV_W];
	logic [DIV_W-1:0] r_s    [DIV_W];
	logic [DIV_W-1:0] q_s    [DIV_W];
	logic [DIV_W-1:0] d_s    [DIV_W];
	logic [1:0]       nb_s   [DIV_W];
	dsd_t             side_s [DIV_W];

	for (genvar k = 0; k < DIV_W; k++) begin : g_st
		localparam int J = DIV_W - 1 - k;
		logic             vp, bitin;
		logic [DIV_W-1:0] rp, qp, dp;
		logic [1:0]       nbp;
		dsd_t             sp;
		logic [DIV_W:0]   rs, rd;

		if (k == 0) begin : g_first
			// top quotient bits are always zero: start from num >> 2
			assign vp  = v_in;
			assign rp  = DIV_W'(num[31:2]);
			assign qp  = '0;
			assign dp  = den;
			assign nbp = num[1:0];
			assign sp  = side_in;
		end else begin : g_next
			assign vp  = v_s[k-1];
			assign rp  = r_s[k-1];
			assign qp  = q_s[k-1];
			assign dp  = d_s[k-1];
			assign nbp = nb_s[k-1];
			assign sp  = side_s[k-1];
		end

		if (J >= 46) begin : g_nbit
			assign bitin = nbp[J-46];
		end else begin : g_zbit
			assign bitin = 1'b0;
		end

		assign rs = {rp, bitin};
		assign rd = rs - {1'b0, dp};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k] <= 1'b0;
			else if (en) v_s[k] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rs >= {1'b0, dp}) begin
					r_s[k] <= rd[DIV_W-1:0];
					q_s[k] <= {qp[DIV_W-2:0], 1'b1};
				end else begin
					r_s[k] <= rs[DIV_W-1:0];
					q_s[k] <= {qp[DIV_W-2:0], 1'b0};
				end
				d_s[k]    <= dp;
				nb_s[k]   <= nbp;
				side_s[k] <= sp;
			end
		end
	end

	assign v_out    = v_s[DIV_W-1];
	assign q        = q_s[DIV_W-1];
	assign side_out = side_s[DIV_W-1];

endmodule

// ===== design/kepler_anomaly_gradient.sv =====
// Top level: Kepler equation gradient, fully pipelined.
//
//  channel  | dir | payload                                              | handshake
//  in_ch    | in  | ecc_anomaly, eccentricity, upstream_grad             | valid/ready
//  out_ch   | out | grad_mean_anomaly, grad_eccentricity                 | valid/ready
//
// One word enters per cycle while the output is not held; the pipeline runs
// through angle fold, one stage per CORDIC iteration, product, denominator,
// 48 divider stages, saturation and two multiply/output stages. The divider chain sets the depth.
// Reset clears only the valid bits. When the output word is held, every stage
// holds, so nothing is dropped or repeated; bubbles are kept in place.
module kepler_anomaly_gradient #(
	parameter int CORDIC_STAGES = kag_pkg::CORDIC_STAGES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	kag_in_if.sink    in_ch,
	kag_out_if.source out_ch
);
	import kag_pkg::*;

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	// angle fold into [-pi/2, pi/2]
	logic signed [32:0] a0, a1, a2;
	logic               flip_c;
	always_comb begin
		a0 = 33'(in_ch.ecc_anomaly);
		if (a0 > ANG_PI) a1 = a0 - ANG_TWO_PI;
		else if (a0 < -ANG_PI) a1 = a0 + ANG_TWO_PI;
		else a1 = a0;
		flip_c = 1'b0;
		a2 = a1;
		if (a1 > ANG_HALF_PI) begin
			a2 = a1 - ANG_PI;
			flip_c = 1'b1;
		end else if (a1 < -ANG_HALF_PI) begin
			a2 = a1 + ANG_PI;
			flip_c = 1'b1;
		end
	end

	logic  v_s1, flip_s1;
	ang_t  z_s1;
	csd_t  side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1         <= a2[31:0];
			flip_s1      <= flip_c;
			side_s1.ecc  <= in_ch.eccentricity;
			side_s1.gneg <= in_ch.upstream_grad[31];
			side_s1.num  <= in_ch.upstream_grad[31] ? 32'(-in_ch.upstream_grad)
			                                        : in_ch.upstream_grad;
		end
	end

	logic  v_c;
	cval_t sn_c, cs_c;
	csd_t  side_c;
	kag_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s1),
		.z_in     (z_s1),
		.flip_in  (flip_s1),
		.side_in  (side_s1),
		.v_out    (v_c),
		.sn       (sn_c),
		.cs       (cs_c),
		.side_out (side_c)
	);

	// e * cos
	logic               v_s2, gneg_s2;
	logic signed [51:0] prod_s2;
	logic [31:0]        num_s2;
	cval_t              sn_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_c;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= 52'($signed({1'b0, side_c.ecc}) * cs_c);
			num_s2  <= side_c.num;
			gneg_s2 <= side_c.gneg;
			sn_s2   <= sn_c;
		end
	end

	// denominator with clamp
	logic signed [51:0] den_full;
	assign den_full = ONE_Q46 - prod_s2;

	logic             v_s3;
	logic [DIV_W-1:0] den_s3;
	logic [31:0]      num_s3;
	dsd_t             dside_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			den_s3        <= (den_full < DEN_MIN) ? DIV_W'(DEN_MIN) : den_full[DIV_W-1:0];
			num_s3        <= num_s2;
			dside_s3.gneg <= gneg_s2;
			dside_s3.sn   <= sn_s2;
		end
	end

	logic             v_d;
	logic [DIV_W-1:0] q_d;
	dsd_t             dside_d;
	kag_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (v_s3),
		.num      (num_s3),
		.den      (den_s3),
		.side_in  (dside_s3),
		.v_out    (v_d),
		.q        (q_d),
		.side_out (dside_d)
	);

	// saturate gM, take magnitudes
	logic             v_s4, gmneg_s4, sneg_s4;
	res_t             gm_s4;
	logic [DIV_W-1:0] gmag_s4;
	logic [CV_W-1:0]  smag_s4;
	res_t             gm_c;
	assign gm_c = sat48(dside_d.gneg, MAG_W'(q_d));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_d;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			gm_s4    <= gm_c;
			gmneg_s4 <= gm_c[OUT_W-1];
			gmag_s4  <= gm_c[OUT_W-1] ? DIV_W'(-gm_c) : DIV_W'(gm_c);
			sneg_s4  <= dside_d.sn[CV_W-1];
			smag_s4  <= dside_d.sn[CV_W-1] ? CV_W'(-dside_d.sn) : CV_W'(dside_d.sn);
		end
	end

	// split product |sin| * |gM|
	logic             v_s5, neg_s5;
	res_t             gm_s5;
	logic [57:0]      phi_s5, plo_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			phi_s5 <= smag_s4 * gmag_s4[47:24];
			plo_s5 <= smag_s4 * gmag_s4[23:0];
			neg_s5 <= sneg_s4 ^ gmneg_s4;
			gm_s5  <= gm_s4;
		end
	end

	logic [MAG_W-1:0] t_c;
	assign t_c = MAG_W'(phi_s5) + MAG_W'(plo_s5 >> 24);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_ch.valid <= 1'b0;
		else if (en) out_ch.valid <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.grad_mean_anomaly <= gm_s5;
			out_ch.grad_eccentricity <= sat48(neg_s5, t_c >> 6);
		end
	end

endmodule

// ===== sim/kepler_anomaly_gradient_tb.sv =====
// Testbench for the Kepler anomaly gradient block: directed corners and random stream with scoreboard.
module kepler_anomaly_gradient_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kag_pkg::*;

	localparam int STAGES = 24;
	localparam int LATENCY = STAGES + 54;
	localparam longint GRAD_MAX = 64'sd140737488355327;
	localparam longint GRAD_MIN = -64'sd140737488355328;

	typedef struct packed {
		logic signed [31:0] anomaly;
		logic        [15:0] ecc;
		logic signed [31:0] grad;
	} word_t;

	typedef struct packed {
		logic signed [47:0] gm;
		logic signed [47:0] ge;
	} grads_t;

	logic clk;
	logic arst_n;
	kag_in_if in_ch();
	kag_out_if out_ch();

	kepler_anomaly_gradient #(.CORDIC_STAGES(STAGES)) DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	word_t  pending_words[$];
	grads_t expected_grads[$];
	int     errors = 0;
	bit     hold_send = 0;
	bit     in_taken = 0;
	int     send_gap = 0;
	int     sink_gap = 0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_q28(int i);
		longint head[10] = '{210828714, 124459457, 65760959, 33381290, 16755422,
			8385879, 4193963, 2097109, 1048571, 524287};
		if (i < 10) return head[i];
		if (i <= 28) return longint'(1) << (28 - i);
		return 0;
	endfunction

	function automatic longint clamp48(bit neg, logic [63:0] mag);
		if (neg) return (mag > 64'(GRAD_MAX)) ? GRAD_MIN : -longint'(mag);
		return (mag > 64'(GRAD_MAX)) ? GRAD_MAX : longint'(mag);
	endfunction

	// Compute both gradients for one word.
	function automatic grads_t kepler_grads(word_t w);
		longint ang, x, y, z, dx, dy, sn, cs, den, gm, ge;
		logic [63:0] num, q, r, den_u, smag, gmag, t;
		bit flip, gneg, sneg;
		grads_t res;
		ang = w.anomaly;
		flip = 0;
		if (ang > 843314857) ang -= 1686629713;
		else if (ang < -843314857) ang += 1686629713;
		if (ang > 421657428) begin
			ang -= 843314857; flip = 1;
		end else if (ang < -421657428) begin
			ang += 843314857; flip = 1;
		end
		x = 652032874; y = 0; z = ang;
		for (int i = 0; i < STAGES && i < 32; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_q28(i);
			end else begin
				x += dx; y -= dy; z += atan_q28(i);
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
		den = (longint'(1) << 46) - longint'(w.ecc) * cs;
		if (den < (longint'(1) << 30)) den = longint'(1) << 30;
		den_u = den;
		gneg = w.grad < 0;
		num = gneg ? 64'(-longint'(w.grad)) : 64'(longint'(w.grad));
		q = num / den_u;
		r = num % den_u;
		for (int k = 0; k < 46; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den_u) begin
				r -= den_u; q |= 64'd1;
			end
		end
		gm = clamp48(gneg, q);
		sneg = sn < 0;
		smag = sneg ? 64'(-sn) : 64'(sn);
		gmag = gm < 0 ? 64'(-gm) : 64'(gm);
		t = smag * (gmag >> 24) + ((smag * (gmag & 64'hFFFFFF)) >> 24);
		ge = clamp48(sneg != (gm < 0), t >> 6);
		res.gm = gm[47:0];
		res.ge = ge[47:0];
		return res;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(9) < 8) return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Remember whether the input word was taken at the last rising edge.
	always @(posedge clk) begin
		in_taken <= arst_n && in_ch.valid && in_ch.ready;
	end

	// Driver: present a word, advance on acceptance.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
		end else if (in_taken) begin
			void'(pending_words.pop_front());
			send_gap = pick_gap();
			if (send_gap == 0 && pending_words.size() != 0 && !hold_send) begin
				in_ch.ecc_anomaly <= pending_words[0].anomaly;
				in_ch.eccentricity <= pending_words[0].ecc;
				in_ch.upstream_grad <= pending_words[0].grad;
			end else begin
				in_ch.valid <= 0;
			end
		end else if (!in_ch.valid) begin
			if (send_gap > 0) send_gap--;
			else if (pending_words.size() != 0 && !hold_send) begin
				in_ch.valid <= 1;
				in_ch.ecc_anomaly <= pending_words[0].anomaly;
				in_ch.eccentricity <= pending_words[0].ecc;
				in_ch.upstream_grad <= pending_words[0].grad;
			end
		end
	end

	// Sink stalls.
	always @(negedge clk) begin
		if (!arst_n) out_ch.ready <= 0;
		else if (sink_gap > 0) begin
			sink_gap--;
			out_ch.ready <= 0;
		end else begin
			sink_gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
			out_ch.ready <= (sink_gap == 0);
		end
	end

	// Monitor: record accepted inputs and check accepted results.
	always @(posedge clk) begin
		grads_t exp_g;
		word_t w;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			w.anomaly = in_ch.ecc_anomaly;
			w.ecc = in_ch.eccentricity;
			w.grad = in_ch.upstream_grad;
			expected_grads.push_back(kepler_grads(w));
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_grads.size() == 0) begin
				errors++;
				$display("%0t: unexpected word gm=%0d ge=%0d", $time,
					out_ch.grad_mean_anomaly, out_ch.grad_eccentricity);
			end else begin
				exp_g = expected_grads.pop_front();
				if (out_ch.grad_mean_anomaly !== exp_g.gm) begin
					errors++;
					$display("%0t: grad_mean_anomaly expected %0d actual %0d", $time,
						exp_g.gm, out_ch.grad_mean_anomaly);
				end
				if (out_ch.grad_eccentricity !== exp_g.ge) begin
					errors++;
					$display("%0t: grad_eccentricity expected %0d actual %0d", $time,
						exp_g.ge, out_ch.grad_eccentricity);
				end
			end
		end
	end

	function automatic word_t rand_word();
		word_t w;
		int sel;
		sel = $urandom_range(9);
		w.anomaly = $urandom();
		w.ecc = 16'($urandom());
		w.grad = $urandom();
		if (sel < 3) w.anomaly = $signed(w.anomaly) >>> $urandom_range(31);
		if (sel == 4) w.ecc = 16'(16'hFFFF - $urandom_range(64));
		if (sel > 6) w.grad = $signed(w.grad) >>> $urandom_range(31);
		return w;
	endfunction

	task automatic add_word(logic signed [31:0] a, logic [15:0] e, logic signed [31:0] g);
		pending_words.push_back({a, e, g});
	endtask

	initial begin
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.ecc_anomaly = 0;
		in_ch.eccentricity = 0;
		in_ch.upstream_grad = 0;
		out_ch.ready = 0;
		// corners: angle extremes, fold edges, eccentricity near one, gradient extremes
		add_word(0, 0, 32'sh10000);
		add_word(32'h7FFFFFFF, 16'hFFFF, 32'h7FFFFFFF);
		add_word(32'h80000000, 16'hFFFF, 32'h80000000);
		add_word(0, 16'hFFFF, 32'h7FFFFFFF);
		add_word(0, 16'hFFFF, 32'h80000000);
		add_word(843314857, 16'h8000, -32'sd65536);
		add_word(843314858, 16'h8000, 32'sd65536);
		add_word(-843314857, 16'h4000, 32'sd1);
		add_word(-843314858, 16'h4000, -32'sd1);
		add_word(421657428, 16'hFFFF, 32'sd123456);
		add_word(421657429, 16'hFFFF, 32'sd123456);
		add_word(-421657428, 16'h0001, -32'sd98765);
		add_word(-421657429, 16'h0001, -32'sd98765);
		add_word(32'sd210828714, 16'hC000, 32'h7FFFFFFF);
		add_word(-32'sd1686629713, 16'h1234, 32'h80000000);
		add_word(32'sh55555555, 16'hAAAA, 32'shAAAAAAAA);
		add_word(32'shAAAAAAAA, 16'h5555, 32'sh55555555);
		add_word(0, 0, 0);
		repeat (7) @(posedge clk);
		arst_n = 1;
		repeat (330) pending_words.push_back(rand_word());
		wait (pending_words.size() == 0);
		// drain fully before the next burst
		hold_send = 1;
		wait (expected_grads.size() == 0);
		hold_send = 0;
		repeat (400) pending_words.push_back(rand_word());
		wait (pending_words.size() == 0);
		wait (expected_grads.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#3ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
